### hdl/pfx_pkg.sv
package pfx_pkg;

    // palette geometry
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_IDX_W   = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;

    // widths of the ycbcr products and their sums
    localparam int PROD_W = 27;
    localparam int SUM_W  = 28;

    // bt.601 ycbcr to rgb coefficients, 16.16 fixed point
    localparam logic signed [18:0] C_Y_RGB  = 19'sd76309;
    localparam logic signed [18:0] C_CR_R   = 19'sd104597;
    localparam logic signed [18:0] C_CR_G   = -19'sd53279;
    localparam logic signed [18:0] C_CB_G   = -19'sd25674;
    localparam logic signed [18:0] C_CB_B   = 19'sd132201;
    localparam logic [SUM_W-1:0]   RND_HALF = SUM_W'(32'h0000_8000);

    // rgb to ycbcr coefficients, all modulo 2^32
    localparam logic [19:0] C_YT_R      = 20'd1052;
    localparam logic [19:0] C_YT_G      = 20'd2065;
    localparam logic [19:0] C_YT_B      = 20'd401;
    localparam logic [31:0] C_CR_RBIG   = 32'd10507932;
    localparam logic [31:0] C_CB_BBIG   = 32'd8312025;
    localparam logic [31:0] C_YT_CR     = 32'd2987;
    localparam logic [31:0] C_YT_CB     = 32'd2363;
    localparam logic [20:0] Y_RND       = 21'h10800;
    localparam logic [31:0] CHROMA_BIAS = 32'h8080_0000;

    // studio luma expansion: floor(d * 255 / 219) = (d * 255 * 76609) >> 24
    localparam logic [7:0]  Y8_LO  = 8'd16;
    localparam logic [7:0]  Y8_HI  = 8'd235;
    localparam logic [7:0]  Y8_SPAN = 8'd219;
    localparam logic [31:0] Y8_MUL = 32'd19535295;

    // source pixel formats
    typedef enum logic [3:0] {
        FMT_PAL1    = 4'd0,
        FMT_PAL2    = 4'd1,
        FMT_PAL4    = 4'd2,
        FMT_PAL8    = 4'd3,
        FMT_X1555   = 4'd4,
        FMT_R565    = 4'd5,
        FMT_RGB888  = 4'd6,
        FMT_XRGB    = 4'd7,
        FMT_Y8      = 4'd8,
        FMT_YCC444  = 4'd9,
        FMT_RGB2YCC = 4'd10
    } fmt_t;

    // one input word as taken from the channel
    typedef struct packed {
        logic        action;
        logic [31:0] pixel_word;
        logic [2:0]  sub_index;
        logic [7:0]  luma;
        logic [7:0]  chroma_blue;
        logic [7:0]  chroma_red;
        logic [7:0]  palette_slot;
        logic [31:0] palette_color;
    } in_word_t;

    // load enables of the pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // contents of the first stage
    typedef struct packed {
        logic              load;
        fmt_t              fmt;
        logic [7:0]        pal_idx;
        logic              pal_hit;
        logic              wr_ok;
        logic [7:0]        slot;
        logic [31:0]       pcolor;
        logic [31:0]       direct;
        logic [PROD_W-1:0] p_y;
        logic [PROD_W-1:0] p_cr_r;
        logic [PROD_W-1:0] p_cr_g;
        logic [PROD_W-1:0] p_cb_g;
        logic [PROD_W-1:0] p_cb_b;
        logic [19:0]       r_w;
        logic [19:0]       g_w;
        logic [19:0]       b_w;
        logic [31:0]       r_big;
        logic [31:0]       b_big;
        logic [7:0]        y8_d;
    } s1_t;

endpackage

### hdl/pfx_if.sv
// input channel: one pixel or one palette load per word
interface pfx_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] pixel_word;
    logic [2:0]  sub_index;
    logic [7:0]  luma;
    logic [7:0]  chroma_blue;
    logic [7:0]  chroma_red;
    logic [7:0]  palette_slot;
    logic [31:0] palette_color;

    modport source (
        output valid, action, pixel_word, sub_index, luma, chroma_blue,
               chroma_red, palette_slot, palette_color,
        input  ready
    );
    modport sink (
        input  valid, action, pixel_word, sub_index, luma, chroma_blue,
               chroma_red, palette_slot, palette_color,
        output ready
    );
endinterface

// output channel: one color per word
interface pfx_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] color_out;

    modport source (output valid, color_out, input ready);
    modport sink (input valid, color_out, output ready);
endinterface

// configuration write channel
interface pfx_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] pixel_format;

    modport source (output valid, pixel_format, input ready);
    modport sink (input valid, pixel_format, output ready);
endinterface

### hdl/pfx_front.sv
module pfx_front
    import pfx_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  fmt_t     fmt,
    input  in_word_t item,
    output s1_t      s1_reg
);

    logic [7:0]        px_byte;
    logic [15:0]       px_half;
    logic [2:0]        sh2;
    logic [7:0]        pal_idx;
    logic              is_pal;
    logic [31:0]       direct;
    logic [7:0]        y8_d;
    logic signed [8:0] y_d;
    logic signed [8:0] cb_d;
    logic signed [8:0] cr_d;
    logic [7:0]        r8;
    logic [7:0]        g8;
    logic [7:0]        b8;
    s1_t               s1_next;

    assign px_byte = item.pixel_word[7:0];
    assign px_half = item.pixel_word[15:0];
    assign sh2     = 3'd6 - {item.sub_index[1:0], 1'b0};

    // palette index from the packed byte, leftmost pixel in the high bits
    always_comb
    begin
        pal_idx = '0;
        is_pal  = 1'b0;
        case (fmt)
            FMT_PAL1:
            begin
                pal_idx = {7'd0, px_byte[3'd7 - item.sub_index]};
                is_pal  = 1'b1;
            end
            FMT_PAL2:
            begin
                pal_idx = {6'd0, px_byte[sh2 +: 2]};
                is_pal  = 1'b1;
            end
            FMT_PAL4:
            begin
                pal_idx = {4'd0, item.sub_index[0] ? px_byte[3:0] : px_byte[7:4]};
                is_pal  = 1'b1;
            end
            FMT_PAL8:
            begin
                pal_idx = px_byte;
                is_pal  = 1'b1;
            end
            default:
            begin
                pal_idx = '0;
                is_pal  = 1'b0;
            end
        endcase
    end

    // direct formats: bit replication and pass-through
    always_comb
    begin
        case (fmt)
            FMT_X1555:
                direct = {8'h00,
                          px_half[14:10], px_half[14:12],
                          px_half[9:5],   px_half[9:7],
                          px_half[4:0],   px_half[4:2]};
            FMT_R565:
                direct = {8'h00,
                          px_half[15:11], px_half[15:13],
                          px_half[10:5],  px_half[10:9],
                          px_half[4:0],   px_half[4:2]};
            FMT_RGB888:
                direct = {8'h00, item.pixel_word[23:0]};
            FMT_XRGB:
                direct = item.pixel_word;
            default:
                direct = '0;
        endcase
    end

    // studio luma clamp
    always_comb
    begin
        if (px_byte < Y8_LO)
        begin
            y8_d = '0;
        end
        else if (px_byte > Y8_HI)
        begin
            y8_d = Y8_SPAN;
        end
        else
        begin
            y8_d = px_byte - Y8_LO;
        end
    end

    // centered ycbcr samples
    assign y_d  = $signed({1'b0, item.luma}) - 9'sd16;
    assign cb_d = $signed({1'b0, item.chroma_blue}) - 9'sd128;
    assign cr_d = $signed({1'b0, item.chroma_red}) - 9'sd128;

    // rgb channels for the reverse mode
    assign r8 = item.pixel_word[23:16];
    assign g8 = item.pixel_word[15:8];
    assign b8 = item.pixel_word[7:0];

    // stage one word
    always_comb
    begin
        s1_next.load    = item.action;
        s1_next.fmt     = fmt;
        s1_next.pal_idx = pal_idx;
        s1_next.pal_hit = is_pal && ({1'b0, pal_idx} < 9'(PAL_ENTRIES));
        s1_next.wr_ok   = {1'b0, item.palette_slot} < 9'(PAL_ENTRIES);
        s1_next.slot    = item.palette_slot;
        s1_next.pcolor  = item.palette_color;
        s1_next.direct  = direct;
        s1_next.p_y     = PROD_W'(PROD_W'(y_d) * PROD_W'(C_Y_RGB));
        s1_next.p_cr_r  = PROD_W'(PROD_W'(cr_d) * PROD_W'(C_CR_R));
        s1_next.p_cr_g  = PROD_W'(PROD_W'(cr_d) * PROD_W'(C_CR_G));
        s1_next.p_cb_g  = PROD_W'(PROD_W'(cb_d) * PROD_W'(C_CB_G));
        s1_next.p_cb_b  = PROD_W'(PROD_W'(cb_d) * PROD_W'(C_CB_B));
        s1_next.r_w     = 20'(r8) * C_YT_R;
        s1_next.g_w     = 20'(g8) * C_YT_G;
        s1_next.b_w     = 20'(b8) * C_YT_B;
        s1_next.r_big   = 32'(r8) * C_CR_RBIG;
        s1_next.b_big   = 32'(b8) * C_CB_BBIG;
        s1_next.y8_d    = y8_d;
    end

    // stage one register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

endmodule

### hdl/pfx_palette.sv
module pfx_palette
    import pfx_pkg::*;
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [PAL_IDX_W-1:0] waddr,
    input  logic [31:0]          wdata,
    input  logic                 re,
    input  logic [PAL_IDX_W-1:0] raddr,
    output logic [31:0]          rdata_reg
);

    logic [31:0] mem [PAL_ENTRIES];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while the stage stalls
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

### hdl/pfx_convert.sv
module pfx_convert
    import pfx_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  s1_t         s1,
    input  logic [31:0] pal_rdata,
    output logic [31:0] color_next
);

    typedef struct packed {
        logic        rev;
        logic        pal_hit;
        logic [31:0] base;
        logic [19:0] yt;
        logic [31:0] r_big;
        logic [31:0] b_big;
    } s2_t;

    typedef struct packed {
        logic        rev;
        logic [31:0] base;
        logic [31:0] p_cr;
        logic [31:0] p_cb;
        logic [7:0]  y_byte;
        logic [31:0] r_big;
        logic [31:0] b_big;
    } s3_t;

    s2_t                     s2_next;
    s2_t                     s2_reg;
    s3_t                     s3_next;
    s3_t                     s3_reg;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] g_sum;
    logic signed [SUM_W-1:0] b_sum;
    logic [31:0]             y8_prod;
    logic [7:0]              y8_q;
    logic [20:0]             y_sum;
    logic [31:0]             cr_x;
    logic [31:0]             cb_x;

    function automatic logic [7:0] sat_chan(input logic signed [SUM_W-1:0] v);
        logic [7:0] res;
        if (v < 0)
        begin
            res = 8'h00;
        end
        else if (v[SUM_W-1:24] != '0)
        begin
            res = 8'hff;
        end
        else
        begin
            res = v[23:16];
        end
        return res;
    endfunction

    // ycbcr sums with rounding
    assign r_sum = SUM_W'($signed(s1.p_y)) + SUM_W'($signed(s1.p_cr_r)) + $signed(RND_HALF);
    assign g_sum = SUM_W'($signed(s1.p_y)) + SUM_W'($signed(s1.p_cr_g))
                 + SUM_W'($signed(s1.p_cb_g)) + $signed(RND_HALF);
    assign b_sum = SUM_W'($signed(s1.p_y)) + SUM_W'($signed(s1.p_cb_b)) + $signed(RND_HALF);

    // luma scale by reciprocal
    assign y8_prod = 32'(s1.y8_d) * Y8_MUL;
    assign y8_q    = y8_prod[31:24];

    // stage two word
    always_comb
    begin
        s2_next.rev     = (s1.fmt == FMT_RGB2YCC);
        s2_next.pal_hit = s1.pal_hit;
        s2_next.yt      = s1.r_w + s1.g_w + s1.b_w;
        s2_next.r_big   = s1.r_big;
        s2_next.b_big   = s1.b_big;
        case (s1.fmt)
            FMT_YCC444:
                s2_next.base = {8'h00, sat_chan(r_sum), sat_chan(g_sum), sat_chan(b_sum)};
            FMT_Y8:
                s2_next.base = {8'h00, y8_q, y8_q, y8_q};
            default:
                s2_next.base = s1.direct;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s2_reg <= s2_next;
        end
    end

    // reverse mode luma and chroma products, palette merge
    assign y_sum = 21'(s2_reg.yt) + Y_RND;

    always_comb
    begin
        s3_next.rev    = s2_reg.rev;
        s3_next.base   = s2_reg.pal_hit ? pal_rdata : s2_reg.base;
        s3_next.p_cr   = 32'(s2_reg.yt) * C_YT_CR;
        s3_next.p_cb   = 32'(s2_reg.yt) * C_YT_CB;
        s3_next.y_byte = y_sum[19:12];
        s3_next.r_big  = s2_reg.r_big;
        s3_next.b_big  = s2_reg.b_big;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            s3_reg <= s3_next;
        end
    end

    // final chroma sums and output select
    assign cr_x = s3_reg.r_big - s3_reg.p_cr + CHROMA_BIAS;
    assign cb_x = s3_reg.b_big - s3_reg.p_cb + CHROMA_BIAS;

    assign color_next = s3_reg.rev ? {8'h00, cr_x[31:24], s3_reg.y_byte, cb_x[31:24]}
                                   : s3_reg.base;

endmodule

### hdl/pixel_format_to_xrgb.sv
// Each pixel word passes the front, palette read, chroma product and output registers.
// Throughput: one word per cycle unless the output stalls; the four register stages
// (front, palette read, chroma products, output) each advance independently and fill
// bubbles on a stall. Palette loads use the write port and give no output word.
// Reset: rst_n is asynchronous active low; it empties the pipeline and sets the
// format to xrgb8888. Palette contents are undefined until loaded.
module pixel_format_to_xrgb
    import pfx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pfx_in_if.sink    pixel,
    pfx_out_if.source color,
    pfx_cfg_if.sink   cfg
);

    fmt_t        fmt_reg;
    in_word_t    item;
    s1_t         s1_word;
    stage_en_t   en;
    logic        rdy_o;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        vo_reg;
    logic [31:0] pal_rdata;
    logic [31:0] color_next;
    logic [31:0] color_reg;

    // format register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_XRGB;
        end
        else if (cfg.valid && cfg.ready)
        begin
            fmt_reg <= fmt_t'(cfg.pixel_format);
        end
    end

    // input word
    assign item.action        = pixel.action;
    assign item.pixel_word    = pixel.pixel_word;
    assign item.sub_index     = pixel.sub_index;
    assign item.luma          = pixel.luma;
    assign item.chroma_blue   = pixel.chroma_blue;
    assign item.chroma_red    = pixel.chroma_red;
    assign item.palette_slot  = pixel.palette_slot;
    assign item.palette_color = pixel.palette_color;

    // stage enables, each stage loads when empty or when its word moves on
    assign rdy_o       = !vo_reg || color.ready;
    assign en.s3       = !v3_reg || rdy_o;
    assign en.s2       = !v2_reg || en.s3;
    assign en.s1       = !v1_reg || en.s2;
    assign pixel.ready = en.s1;

    // valid bits, loads drop out after the palette stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                v1_reg <= pixel.valid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg && !s1_word.load;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy_o)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    pfx_front u_front (
        .clk    (clk),
        .en     (en.s1),
        .fmt    (fmt_reg),
        .item   (item),
        .s1_reg (s1_word)
    );

    // palette writes and reads happen at the same stage so order is kept
    pfx_palette u_palette (
        .clk       (clk),
        .we        (v1_reg && s1_word.load && s1_word.wr_ok && en.s2),
        .waddr     (s1_word.slot[PAL_IDX_W-1:0]),
        .wdata     (s1_word.pcolor),
        .re        (en.s2),
        .raddr     (s1_word.pal_idx[PAL_IDX_W-1:0]),
        .rdata_reg (pal_rdata)
    );

    pfx_convert u_convert (
        .clk        (clk),
        .en         (en),
        .s1         (s1_word),
        .pal_rdata  (pal_rdata),
        .color_next (color_next)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (rdy_o)
        begin
            color_reg <= color_next;
        end
    end

    assign color.valid     = vo_reg;
    assign color.color_out = color_reg;

    // a palette load never turns into an output word
    a_load_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && s1_word.load && en.s2) |=> !v2_reg)
        else $error("palette load reached the conversion stage");

    // input backpressure only when every stage holds a word
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> (v1_reg && v2_reg && v3_reg && vo_reg))
        else $error("input stalled with an empty stage");

    // a stalled last stage keeps its word
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !rdy_o) |=> v3_reg)
        else $error("stage three word lost during stall");

endmodule

### verif/tb_pixel_format_to_xrgb.sv
module tb_pixel_format_to_xrgb
    import pfx_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       ACT_CONVERT   = 1'b0;
    localparam logic       ACT_LOAD      = 1'b1;
    localparam logic [3:0] FMT_CODE_MAX  = 4'd15;
    localparam int         RANDOM_ITEMS  = 950;
    localparam int         DRAIN_CYCLES  = 10;
    localparam int         CYCLE_LIMIT   = 600000;

    // expected colors for the output channel, with its own palette and format copy
    class color_scoreboard;
        bit [31:0]  color_lut [PAL_ENTRIES];
        logic [3:0] cur_format;
        bit [31:0]  expected_colors [$];
        int         errors;

        function new();
            cur_format = FMT_XRGB;
            errors     = 0;
            foreach (color_lut[i])
                color_lut[i] = '0;
        endfunction

        function void set_format(logic [3:0] f);
            cur_format = f;
        endfunction

        // palette entry read by a pixel byte, -1 when the format has no palette
        function int lut_index(bit [7:0] b, bit [2:0] x);
            int sh;
            case (cur_format)
                FMT_PAL1:
                begin
                    sh = 7 - int'(x);
                    return int'((b >> sh) & 8'h01);
                end
                FMT_PAL2:
                begin
                    sh = 6 - 2 * int'(x[1:0]);
                    return int'((b >> sh) & 8'h03);
                end
                FMT_PAL4: return x[0] ? int'(b[3:0]) : int'(b[7:4]);
                FMT_PAL8: return int'(b);
                default:  return -1;
            endcase
        endfunction

        function bit [31:0] clip_channel(int v);
            if (v < 0)
                return 32'h0;
            if (v > 32'h00ff_ffff)
                return 32'h00ff_ffff;
            return 32'(v);
        endfunction

        // bt.601 fixed point, each channel saturated
        function bit [31:0] ycc_to_xrgb(bit [7:0] y0, bit [7:0] cb0, bit [7:0] cr0);
            int y, cb, cr, y2;
            bit [31:0] r, g, b;
            y  = int'(y0) - 16;
            cb = int'(cb0) - 128;
            cr = int'(cr0) - 128;
            y2 = y * 76309 + 32'sh8000;
            r  = clip_channel(y2 + cr * 104597);
            g  = clip_channel(y2 - cr * 53279 - cb * 25674);
            b  = clip_channel(y2 + cb * 132201);
            return (r & 32'hff_0000) + ((g & 32'hff_0000) >> 8) + (b >> 16);
        endfunction

        // reverse packing, everything wraps at 32 bits
        function bit [31:0] xrgb_to_ycc(bit [31:0] c);
            bit [31:0] r, g, b, yt, y, cr, cb, t;
            r  = {24'h0, c[23:16]};
            g  = {24'h0, c[15:8]};
            b  = {24'h0, c[7:0]};
            yt = 32'd1052 * r + 32'd2065 * g + 32'd401 * b;
            y  = (yt + 32'h0001_0800) >> 4;
            t  = 32'd10507932 * r - yt * 32'd2987 + 32'h8080_0000;
            cr = t >> 8;
            t  = 32'd8312025 * b - yt * 32'd2363 + 32'h8080_0000;
            cb = t >> 24;
            return (cb & 32'hff) + (y & 32'hff00) + (cr & 32'hff_0000);
        endfunction

        function bit [31:0] predict_color(in_word_t w);
            bit [31:0] c, rgb, rb, g, t;
            int idx, l;
            if (cur_format == FMT_YCC444)
                return ycc_to_xrgb(w.luma, w.chroma_blue, w.chroma_red);
            if (cur_format == FMT_RGB2YCC)
                return xrgb_to_ycc(w.pixel_word);
            idx = lut_index(w.pixel_word[7:0], w.sub_index);
            if (idx >= 0)
                return color_lut[idx];
            c = {16'h0, w.pixel_word[15:0]};
            case (cur_format)
                FMT_X1555:
                begin
                    rgb = ((c & 32'h7c00) << 9) + ((c & 32'h03e0) << 6) + ((c & 32'h001f) << 3);
                    return rgb + ((rgb >> 5) & 32'h07_0707);
                end
                FMT_R565:
                begin
                    g  = c & 32'h07e0;
                    rb = ((c & 32'hf800) << 8) + ((c & 32'h001f) << 3);
                    return rb + ((rb >> 5) & 32'h07_0007) + (g << 5) + ((g >> 1) & 32'h0300);
                end
                FMT_RGB888: return w.pixel_word & 32'hff_ffff;
                FMT_XRGB:   return w.pixel_word;
                FMT_Y8:
                begin
                    // studio luma clamped into 16..235 before expansion
                    l = int'(w.pixel_word[7:0]);
                    if (l < 16)
                        l = 16;
                    if (l > 235)
                        l = 235;
                    t = 32'((l - 16) * 255 / 219);
                    return t * 32'h01_0101;
                end
                default:    return 32'h0;
            endcase
        endfunction

        // one accepted input word
        function void record_word(in_word_t w);
            if (w.action == ACT_LOAD)
                color_lut[w.palette_slot] = w.palette_color;
            else
                expected_colors.push_back(predict_color(w));
        endfunction

        // one accepted output word
        function void check_color(bit [31:0] got);
            bit [31:0] exp_color;
            if (expected_colors.size() == 0)
            begin
                $error("color_out: unexpected word, expected none actual 0x%08h", got);
                errors++;
                return;
            end
            exp_color = expected_colors.pop_front();
            if (got !== exp_color)
            begin
                $error("color_out: expected 0x%08h actual 0x%08h", exp_color, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady_flow;
    int   items_sent;
    int   cycle_count;
    bit   lut_written [PAL_ENTRIES];
    color_scoreboard sb;

    pfx_in_if  pix_if ();
    pfx_out_if col_if ();
    pfx_cfg_if cfg_if ();

    pixel_format_to_xrgb dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pix_if),
        .color (col_if),
        .cfg   (cfg_if)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // idle length, mostly short with a few long ones
    function int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function in_word_t random_word();
        in_word_t w;
        w.action        = ACT_CONVERT;
        w.pixel_word    = $urandom;
        w.sub_index     = 3'($urandom_range(0, 7));
        w.luma          = 8'($urandom_range(0, 255));
        w.chroma_blue   = 8'($urandom_range(0, 255));
        w.chroma_red    = 8'($urandom_range(0, 255));
        w.palette_slot  = 8'($urandom_range(0, 255));
        w.palette_color = $urandom;
        return w;
    endfunction

    // present one word on the input channel and hold it until taken
    task automatic send_word(in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid         <= 1'b1;
        pix_if.action        <= w.action;
        pix_if.pixel_word    <= w.pixel_word;
        pix_if.sub_index     <= w.sub_index;
        pix_if.luma          <= w.luma;
        pix_if.chroma_blue   <= w.chroma_blue;
        pix_if.chroma_red    <= w.chroma_red;
        pix_if.palette_slot  <= w.palette_slot;
        pix_if.palette_color <= w.palette_color;
        do
            @(posedge clk);
        while (pix_if.ready !== 1'b1);
        sb.record_word(w);
        items_sent++;
    endtask

    task automatic load_palette(bit [7:0] slot, bit [31:0] color);
        in_word_t w;
        w               = random_word();
        w.action        = ACT_LOAD;
        w.palette_slot  = slot;
        w.palette_color = color;
        send_word(w);
        lut_written[slot] = 1'b1;
    endtask

    // convert a pixel, loading its palette entry first when still unwritten
    task automatic convert_pixel(in_word_t w);
        int idx;
        w.action = ACT_CONVERT;
        idx = sb.lut_index(w.pixel_word[7:0], w.sub_index);
        if (idx >= 0 && !lut_written[idx])
            load_palette(8'(idx), $urandom);
        send_word(w);
    endtask

    task automatic convert_raw(bit [31:0] pw, bit [2:0] x);
        in_word_t w;
        w            = random_word();
        w.pixel_word = pw;
        w.sub_index  = x;
        convert_pixel(w);
    endtask

    task automatic convert_ycc(bit [7:0] y, bit [7:0] cb, bit [7:0] cr);
        in_word_t w;
        w             = random_word();
        w.luma        = y;
        w.chroma_blue = cb;
        w.chroma_red  = cr;
        convert_pixel(w);
    endtask

    // format change only once the pipeline has drained
    task automatic write_format(logic [3:0] f);
        pix_if.valid <= 1'b0;
        while (sb.expected_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.pixel_format <= f;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        sb.set_format(f);
    endtask

    // output side with random stalls
    initial
    begin
        int hold;
        int r;
        hold = 0;
        col_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (steady_flow)
            begin
                col_if.ready <= 1'b1;
                hold = 0;
            end
            else if (hold > 0)
                hold--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    col_if.ready <= 1'b1;
                    hold = $urandom_range(0, 7);
                end
                else if (r < 95)
                begin
                    col_if.ready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end
                else
                begin
                    col_if.ready <= 1'b0;
                    hold = $urandom_range(4, 40);
                end
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && col_if.valid === 1'b1 && col_if.ready === 1'b1)
            sb.check_color(col_if.color_out);
    end

    // run time limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int order [16];
        int j, tmp, phase_len, random_target;
        logic [3:0] f;
        in_word_t w;

        sb = new();
        steady_flow = 1'b0;
        items_sent  = 0;
        foreach (lut_written[i])
            lut_written[i] = 1'b0;
        rst_n                = 1'b0;
        pix_if.valid         = 1'b0;
        pix_if.action        = ACT_CONVERT;
        pix_if.pixel_word    = '0;
        pix_if.sub_index     = '0;
        pix_if.luma          = '0;
        pix_if.chroma_blue   = '0;
        pix_if.chroma_red    = '0;
        pix_if.palette_slot  = '0;
        pix_if.palette_color = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.pixel_format  = FMT_XRGB;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: format after reset passes words through
        convert_raw(32'h0000_0000, 3'd0);
        convert_raw(32'hffff_ffff, 3'd7);
        load_palette(8'd0, 32'hffff_ffff);
        load_palette(8'd255, 32'h0000_0000);
        load_palette(8'd1, $urandom);

        // leftmost and rightmost pixel of a packed byte
        write_format(FMT_PAL1);
        convert_raw(32'h0000_0080, 3'd0);
        convert_raw(32'hffff_ff7f, 3'd0);
        convert_raw(32'h0000_0001, 3'd7);

        write_format(FMT_PAL8);
        convert_raw(32'h0000_00ff, 3'd0);
        convert_raw(32'hffff_ff00, 3'd5);

        // top bit of 1555 has no effect
        write_format(FMT_X1555);
        convert_raw(32'h0000_7fff, 3'd0);
        convert_raw(32'hffff_8000, 3'd0);

        write_format(FMT_R565);
        convert_raw(32'h0000_ffff, 3'd0);
        convert_raw(32'hffff_0000, 3'd0);

        // luma below, at and above the studio range
        write_format(FMT_Y8);
        convert_raw(32'h0000_000f, 3'd0);
        convert_raw(32'h0000_00f0, 3'd0);
        convert_raw(32'h0000_0010, 3'd0);
        convert_raw(32'h0000_00eb, 3'd0);

        // chroma extremes drive some channels into saturation
        write_format(FMT_YCC444);
        convert_ycc(8'd0, 8'd255, 8'd255);
        convert_ycc(8'd255, 8'd0, 8'd0);
        convert_ycc(8'd255, 8'd255, 8'd255);

        write_format(FMT_RGB2YCC);
        convert_raw(32'hffff_ffff, 3'd0);
        convert_raw(32'h0000_0000, 3'd0);

        // unused format code gives zero
        write_format(FMT_CODE_MAX);
        convert_raw($urandom, 3'd0);

        // random phases, first every code once in shuffled order
        for (int i = 0; i < 16; i++)
            order[i] = i;
        for (int i = 15; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        random_target = items_sent + RANDOM_ITEMS;
        for (int p = 0; items_sent < random_target; p++)
        begin
            if (p < 16)
                f = 4'(order[p]);
            else if ($urandom_range(0, 9) < 8)
                f = 4'($urandom_range(0, FMT_RGB2YCC));
            else
                f = 4'($urandom_range(0, FMT_CODE_MAX));
            steady_flow = 1'b0;
            write_format(f);
            steady_flow = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(30, 90);
            for (int k = 0; k < phase_len && items_sent < random_target; k++)
            begin
                w = random_word();
                if ($urandom_range(0, 9) == 0)
                    load_palette(w.palette_slot, w.palette_color);
                else
                    convert_pixel(w);
            end
        end

        // drain and finish
        steady_flow = 1'b0;
        pix_if.valid <= 1'b0;
        while (sb.expected_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_colors.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
